// ===== sv/kleb_pkg.sv =====
// Shared constants for the keyboard line edit buffer.
`timescale 1ns / 1ps
package kleb_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int LINE_MAX   = 63;
    localparam int TERMINALS  = 3;

    localparam int IDX_W  = $clog2(LINE_DEPTH);
    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int TIDX_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int STORE_DEPTH = TERMINALS * LINE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int TERM_W   = 2;
    localparam int KEY_W    = 8;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [KEY_W-1:0] KEY_NUL       = 8'd0;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 8'd10;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_BYTE       = 3'd0,
        ST_TAKEN      = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_COMMITTED  = 3'd3,
        ST_NOT_READY  = 3'd4,
        ST_BAD_LENGTH = 3'd5
    } status_t;

endpackage

// ===== sv/kleb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module kleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/keyboard_line_edit_buffer.sv =====
// Top level of the cooked-mode line editor for several terminals.
//
// Usage:
//   One request enters on the s_axis channel. s_axis_tuser is cmd (0 key,
//   1 read); s_axis_tdata carries terminal, key and max_bytes. Results leave
//   on the m_axis channel; m_axis_tuser is the status, m_axis_tdata carries
//   the line byte and the returned count, m_axis_tlast marks the final result
//   of a request.
//   A key request is latched in S_IDLE; in S_WORK the line is edited and the
//   single result is loaded into the output register.
//   A read request returns N results (N up to 64): the line memory has one
//   read port with a registered output, so the sequencer fetches the first
//   byte in S_WORK and then streams one result per cycle unless m_axis stalls.
//   s_axis_tready is high only while the sequencer is idle; a finished result
//   may still wait in the output register when the next request is latched.
//   A stall on m_axis holds the output register and freezes the sequencer.
//   Reset clears every line length and commit bit; the line memory is not
//   cleared, since only bytes written by an append are ever read back.
`timescale 1ns / 1ps
module keyboard_line_edit_buffer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] terminal, [9:2] key, [16:10] max_bytes, [23:17] zero
    input  logic [kleb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] data, [14:8] count, [15] zero
    output logic [kleb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [kleb_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    import kleb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_STREAM
    } state_t;

    state_t state_reg;

    logic              cmd_reg;
    logic [TERM_W-1:0] term_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  maxb_reg;

    logic [LEN_W-1:0] len_reg [TERMINALS];
    logic             com_reg [TERMINALS];

    logic [IDX_W-1:0] emit_idx_reg;
    logic [CNT_W-1:0] total_reg;

    logic             out_valid_reg;
    status_t          status_reg;
    logic [KEY_W-1:0] data_reg;
    logic             last_reg;
    logic [CNT_W-1:0] count_reg;

    logic              out_free;
    logic              accept;
    logic [TIDX_W-1:0] tidx;
    logic              term_ok;
    logic [LEN_W-1:0]  cur_len;
    logic              cur_com;
    logic [ADDR_W-1:0] base;

    status_t          key_status;
    logic             key_write;
    logic             key_commit;
    logic [LEN_W-1:0] key_len;

    logic             read_ok;
    logic [CNT_W-1:0] len_plus1;
    logic [CNT_W-1:0] rd_total;
    logic             last_emit;
    logic             more_fetch;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_ridx;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tidx    = term_reg[TIDX_W-1:0];
    assign term_ok = (int'(term_reg) < TERMINALS);
    assign cur_len = len_reg[tidx];
    assign cur_com = com_reg[tidx];
    assign base    = ADDR_W'(tidx) * ADDR_W'(LINE_DEPTH);

    // Key edit decision
    always_comb
    begin
        key_status = ST_IGNORED;
        key_write  = 1'b0;
        key_commit = 1'b0;
        key_len    = cur_len;
        if (!term_ok || cur_com || key_reg == KEY_NUL
            || (key_reg == KEY_BACKSPACE && cur_len == '0))
        begin
            key_status = ST_IGNORED;
        end
        else if (key_reg == KEY_BACKSPACE)
        begin
            key_status = ST_TAKEN;
            key_len    = cur_len - LEN_W'(1);
        end
        else if (key_reg == KEY_ENTER)
        begin
            key_status = ST_COMMITTED;
            key_commit = 1'b1;
        end
        else if (int'(cur_len) < LINE_MAX)
        begin
            key_status = ST_TAKEN;
            key_write  = 1'b1;
            key_len    = cur_len + LEN_W'(1);
        end
    end

    assign read_ok   = term_ok && cur_com;
    assign len_plus1 = CNT_W'(cur_len) + CNT_W'(1);
    assign rd_total  = (len_plus1 > maxb_reg) ? maxb_reg : len_plus1;

    assign last_emit  = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == total_reg;
    assign more_fetch = (CNT_W'(emit_idx_reg) + CNT_W'(2)) < total_reg;

    // Line memory ports
    always_comb
    begin
        ram_we   = (state_reg == S_WORK) && out_free && (cmd_reg == CMD_KEY) && key_write;
        ram_re   = 1'b0;
        ram_ridx = '0;
        if (state_reg == S_WORK && out_free && cmd_reg == CMD_READ && read_ok
            && maxb_reg != '0 && rd_total > CNT_W'(1))
        begin
            ram_re = 1'b1;
        end
        else if (state_reg == S_STREAM && out_free && more_fetch)
        begin
            ram_re   = 1'b1;
            ram_ridx = emit_idx_reg + IDX_W'(1);
        end
    end

    assign ram_waddr = base + ADDR_W'(cur_len);
    assign ram_raddr = base + ADDR_W'(ram_ridx);

    kleb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_KEY;
            term_reg      <= '0;
            key_reg       <= '0;
            maxb_reg      <= '0;
            emit_idx_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_IGNORED;
            data_reg      <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < TERMINALS; i++)
            begin
                len_reg[i] <= '0;
                com_reg[i] <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    // drop a result once the receiver takes it
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        cmd_reg   <= s_axis_tuser;
                        term_reg  <= s_axis_tdata[TERM_W-1:0];
                        key_reg   <= s_axis_tdata[TERM_W+KEY_W-1:TERM_W];
                        maxb_reg  <= s_axis_tdata[TERM_W+KEY_W+CNT_W-1:TERM_W+KEY_W];
                        state_reg <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    if (out_free)
                    begin
                        // hold the output empty while the first byte of a read is fetched
                        out_valid_reg <= !(cmd_reg == CMD_READ && read_ok && maxb_reg != '0);
                        data_reg      <= '0;
                        last_reg      <= 1'b1;
                        count_reg     <= '0;
                        state_reg     <= S_IDLE;
                        if (cmd_reg == CMD_KEY)
                        begin
                            status_reg <= key_status;
                            if (term_ok)
                            begin
                                len_reg[tidx] <= key_len;
                                if (key_commit)
                                begin
                                    com_reg[tidx] <= 1'b1;
                                end
                            end
                        end
                        else if (!read_ok)
                        begin
                            status_reg <= ST_NOT_READY;
                        end
                        else
                        begin
                            com_reg[tidx] <= 1'b0;
                            if (maxb_reg == '0)
                            begin
                                status_reg <= ST_BAD_LENGTH;
                            end
                            else
                            begin
                                // start streaming; first byte is fetched now unless only the newline returns
                                emit_idx_reg  <= '0;
                                total_reg     <= rd_total;
                                state_reg     <= S_STREAM;
                            end
                        end
                    end
                end
                S_STREAM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_BYTE;
                        if (last_emit)
                        begin
                            data_reg      <= KEY_ENTER;
                            last_reg      <= 1'b1;
                            count_reg     <= total_reg;
                            len_reg[tidx] <= '0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            data_reg     <= ram_rdata;
                            last_reg     <= 1'b0;
                            count_reg    <= '0;
                            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {1'b0, count_reg, data_reg};

    // a line being streamed has already dropped its commit bit
    a_stream_uncommitted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STREAM |-> !com_reg[tidx])
        else $error("commit bit still set during read stream");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STREAM |-> (CNT_W'(emit_idx_reg) < total_reg
                                   && total_reg <= maxb_reg))
        else $error("stream index beyond returned count");

    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && count_reg != '0) |-> (last_reg && status_reg == ST_BYTE))
        else $error("count shown on a result that is not the final line byte");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WORK && term_ok |-> int'(cur_len) <= LINE_MAX)
        else $error("line length beyond limit");

endmodule

// ===== tb/kleb_line_checker.sv =====
// Scoreboard for the line edit buffer: predicts results per request and compares them.
`timescale 1ns / 1ps
module kleb_line_checker
    import kleb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [STATUS_W-1:0]   m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    mismatch_count,
    output int                    results_owed
);

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   data;
        logic               last;
        logic [CNT_W-1:0]   count;
    } line_result_t;

    logic [KEY_W-1:0] line_bytes [TERMINALS][LINE_DEPTH];
    int               line_len   [TERMINALS];
    bit               line_ready [TERMINALS];
    line_result_t     owed_results [$];

    function automatic string describe(input line_result_t r);
        return $sformatf("st=%0d d=%0h l=%0b c=%0d", r.status, r.data, r.last, r.count);
    endfunction

    task automatic push_result(input status_t status, input logic [KEY_W-1:0] data,
                               input logic last, input int count);
        line_result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        r.count  = CNT_W'(count);
        owed_results.push_back(r);
    endtask

    task automatic predict_request(input logic cmd, input logic [TERM_W-1:0] term,
                                   input logic [KEY_W-1:0] key,
                                   input logic [CNT_W-1:0] max_bytes);
        int t;
        int total;
        status_t st;
        t = int'(term);
        if (cmd == CMD_KEY)
        begin
            st = ST_IGNORED;
            if (t < TERMINALS && !line_ready[t] && key != KEY_NUL
                && !(key == KEY_BACKSPACE && line_len[t] == 0))
            begin
                if (key == KEY_BACKSPACE)
                begin
                    line_len[t]--;
                    st = ST_TAKEN;
                end
                else if (key == KEY_ENTER)
                begin
                    line_ready[t] = 1'b1;
                    st = ST_COMMITTED;
                end
                else if (line_len[t] < LINE_MAX)
                begin
                    line_bytes[t][line_len[t]] = key;
                    line_len[t]++;
                    st = ST_TAKEN;
                end
            end
            push_result(st, '0, 1'b1, 0);
        end
        else if (t >= TERMINALS || !line_ready[t])
            push_result(ST_NOT_READY, '0, 1'b1, 0);
        else
        begin
            line_ready[t] = 1'b0;
            // zero length drops the commit but keeps the line for more editing
            if (max_bytes == '0)
                push_result(ST_BAD_LENGTH, '0, 1'b1, 0);
            else
            begin
                total = line_len[t] + 1;
                if (total > int'(max_bytes))
                    total = int'(max_bytes);
                for (int i = 0; i + 1 < total; i++)
                    push_result(ST_BYTE, line_bytes[t][i], 1'b0, 0);
                push_result(ST_BYTE, KEY_ENTER, 1'b1, total);
                line_len[t] = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        line_result_t got;
        if (!rst_n)
        begin
            owed_results.delete();
            mismatch_count = 0;
            for (int t = 0; t < TERMINALS; t++)
            begin
                line_len[t]   = 0;
                line_ready[t] = 1'b0;
            end
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[9:2],
                                s_axis_tdata[16:10]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tuser);
                got.data   = m_axis_tdata[7:0];
                got.last   = m_axis_tlast;
                got.count  = m_axis_tdata[14:8];
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, describe(got));
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch, expected %s, actual %s",
                                 $time, describe(want), describe(got));
                        mismatch_count++;
                    end
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

// ===== tb/keyboard_line_edit_buffer_tb.sv =====
// Top of the line edit buffer testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module keyboard_line_edit_buffer_tb;
    import kleb_pkg::*;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 80;
    localparam int PHASE_REQUESTS  = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    int mismatch_count;
    int results_owed;
    int cycle_count;
    int requests_sent;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;

    keyboard_line_edit_buffer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    kleb_line_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic cmd, input int term, input int key,
                                input int max_bytes);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, CNT_W'(max_bytes), KEY_W'(key), TERM_W'(term)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Type a line with random content, commit it and read it back.
    task automatic type_and_read(input int term, input int n_keys);
        int key;
        for (int i = 0; i < n_keys; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                key = int'(KEY_BACKSPACE);
            else
            begin
                do
                    key = $urandom_range(1, 255);
                while (key == int'(KEY_ENTER) || key == int'(KEY_BACKSPACE));
            end
            send_request(CMD_KEY, term, key, $urandom_range(0, 64));
        end
        send_request(CMD_KEY, term, int'(KEY_ENTER), $urandom_range(0, 64));
        send_request(CMD_READ, term, $urandom_range(0, 255),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 64));
    endtask

    task automatic random_phase(input int n_requests, input bit start_long);
        int stop_at;
        stop_at = requests_sent + n_requests;
        if (start_long)
            type_and_read($urandom_range(0, TERMINALS - 1), 70);
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 70)
                type_and_read($urandom_range(0, TERMINALS - 1),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                                          : $urandom_range(0, 12));
            else
                send_request(1'($urandom_range(0, 1)), $urandom_range(0, 3),
                             $urandom_range(0, 255), $urandom_range(0, 64));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_KEY;
        hold_off_req  = 1'b0;
        requests_sent = 0;
        send_idle_pct = 17;
        recv_idle_pct = 86;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_KEY,  0, 8'h41, 0);
        send_request(CMD_KEY,  0, int'(KEY_NUL), 0);
        send_request(CMD_READ, 0, 0, 64);
        send_request(CMD_KEY,  1, int'(KEY_BACKSPACE), 0);
        send_request(CMD_KEY,  0, 8'hFF, 0);
        send_request(CMD_KEY,  0, int'(KEY_BACKSPACE), 0);
        send_request(CMD_KEY,  0, 8'h80, 0);
        send_request(CMD_KEY,  0, int'(KEY_ENTER), 0);
        send_request(CMD_KEY,  0, 8'h78, 0);
        // zero length: commit dropped, line kept
        send_request(CMD_READ, 0, 8'hFF, 0);
        send_request(CMD_KEY,  0, 8'h42, 127);
        send_request(CMD_KEY,  0, int'(KEY_ENTER), 0);
        send_request(CMD_READ, 0, 0, 64);
        send_request(CMD_KEY,  3, 8'h5A, 0);
        send_request(CMD_READ, 3, 0, 64);
        send_request(CMD_READ, 1, 0, 64);
        send_request(CMD_KEY,  2, 8'h71, 0);
        send_request(CMD_KEY,  2, 8'h72, 0);
        send_request(CMD_KEY,  2, int'(KEY_ENTER), 0);
        // truncated to a single byte: only the newline comes back
        send_request(CMD_READ, 2, 0, 1);
        send_request(CMD_KEY,  1, 8'h61, 0);
        send_request(CMD_KEY,  1, 8'h62, 0);
        send_request(CMD_KEY,  1, int'(KEY_ENTER), 0);
        send_request(CMD_READ, 1, 0, 2);

        random_phase(PHASE_REQUESTS, 1'b1);

        send_idle_pct = 86;
        recv_idle_pct = 17;
        random_phase(PHASE_REQUESTS, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        random_phase(PHASE_REQUESTS, 1'b1);

        s_axis_tvalid <= 1'b0;
        // let the scoreboard book the final request before draining
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
